// ===== hw/rtl/ncl1_pkg.sv =====
`default_nettype none

package ncl1_pkg;

  // sizing of the stores
  localparam int MAX_CLUSTERS = 256;
  localparam int MAX_DIMS     = 32;

  // fixed field widths
  localparam int CmdW    = 2;
  localparam int ClIdxW  = 8;
  localparam int DimIdxW = 5;
  localparam int CoordW  = 16;
  localparam int LabelW  = 16;
  localparam int NclCfgW = 9;
  localparam int NdCfgW  = 6;
  localparam int CfgW    = 9;
  localparam int CfgIdxW = 1;

  // derived widths
  localparam int ClAw   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DimAw  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CentDepth = MAX_CLUSTERS * MAX_DIMS;
  localparam int CentAw = (CentDepth > 1) ? $clog2(CentDepth) : 1;
  localparam int AbsW   = CoordW;
  localparam int DistW  = AbsW + $clog2(MAX_DIMS);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CLUSTERS = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_DIMS     = 1'b1;

  typedef enum logic [CmdW-1:0] {
    CMD_CENTROID = 2'd0,
    CMD_LABEL    = 2'd1,
    CMD_POINT    = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                        command;
    logic [ClIdxW-1:0]           cluster_index;
    logic [DimIdxW-1:0]          dim_index;
    logic signed [CoordW-1:0]    coordinate;
    logic [LabelW-1:0]           label_value;
    logic                        point_end;
  } req_t;

  typedef struct packed {
    logic [LabelW-1:0] assigned_label;
    logic [ClIdxW-1:0] nearest_cluster;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ncl1_ram.sv =====
`default_nettype none

module ncl1_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_centroid_l1_assign_unit.sv =====
`default_nettype none

// nearest centroid search by manhattan distance
//
// requests come in on req_i and are taken at a clock edge with start high
// and busy low. a centroid coordinate or label request is written into its
// store in that cycle and the block stays free. a point coordinate request
// goes into the point buffer; when it carries point_end the block raises
// busy and searches the first clusters_in_use centroids over the first
// dims_in_use coordinates, lowest index winning on a tie.
// the search streams one centroid coordinate per cycle out of the centroid
// ram, and the centroid ram read port paces it.
// the result is shown on res_o for exactly one cycle with done_o high; there
// is no back pressure, the receiver must take it. busy drops in that same
// cycle, so the next request may already be taken.
// reset clears control state and sets clusters_in_use to 256 and dims_in_use
// to 32; the stores are not cleared and must be written before they are read.
// configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) are for idle time.

module nearest_centroid_l1_assign_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire ncl1_pkg::req_t              req_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [ncl1_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ncl1_pkg::CfgW-1:0]   cfg_data_i,
  output logic                             done_o,
  output ncl1_pkg::res_t                   res_o
);

  import ncl1_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_LABEL
  } state_e;

  state_e state_q;

  // configuration registers
  logic [NclCfgW-1:0] clusters_q;
  logic [NdCfgW-1:0]  dims_q;

  // saturated limits, minus one, latched at search start
  logic [ClAw-1:0]  ncl_m1_d, ncl_m1_q;
  logic [DimAw-1:0] ndim_m1_d, ndim_m1_q;

  // issue counters
  logic [ClAw-1:0]   cl_q;
  logic [DimAw-1:0]  dim_q;
  logic [CentAw-1:0] cent_addr_q;
  logic [CentAw-1:0] base_q;
  logic              issue_done_q;

  // pipeline valids and flags
  logic s1_v_q, s1_first_q, s1_last_q, s1_lastcl_q;
  logic s2_v_q, s2_first_q, s2_last_q, s2_lastcl_q;
  logic s3_v_q, s3_lastcl_q;
  logic fin_q;

  // datapath
  logic [AbsW-1:0]  absdiff_d, absdiff_q;
  logic [DistW-1:0] acc_d, acc_q;
  logic [DistW-1:0] dist_q;
  logic [DistW-1:0] best_dist_q;
  logic [ClAw-1:0]  best_q;
  logic [ClAw-1:0]  cmp_idx_q;

  logic done_q;
  res_t res_q;

  // ram ports
  logic              accept;
  logic              cent_we, label_we, point_we;
  logic [CentAw-1:0] cent_waddr;
  logic [CoordW-1:0] cent_rdata, point_rdata;
  logic [LabelW-1:0] label_rdata;
  logic              cl_ok, dim_ok;
  logic signed [CoordW:0] diff;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // writes beyond the store size are dropped
  assign cl_ok  = (int'(req_i.cluster_index) < MAX_CLUSTERS);
  assign dim_ok = (int'(req_i.dim_index) < MAX_DIMS);

  assign cent_we  = accept && (req_i.command == CMD_CENTROID) && cl_ok && dim_ok;
  assign label_we = accept && (req_i.command == CMD_LABEL) && cl_ok;
  assign point_we = accept && (req_i.command == CMD_POINT) && dim_ok;

  assign cent_waddr = CentAw'(req_i.cluster_index) * CentAw'(MAX_DIMS)
                      + CentAw'(req_i.dim_index);

  ncl1_ram #(
    .WIDTH (CoordW),
    .DEPTH (CentDepth)
  ) u_cent_ram (
    .clk_i   (clk_i),
    .we_i    (cent_we),
    .waddr_i (cent_waddr),
    .wdata_i (req_i.coordinate),
    .raddr_i (cent_addr_q),
    .rdata_o (cent_rdata)
  );

  ncl1_ram #(
    .WIDTH (LabelW),
    .DEPTH (MAX_CLUSTERS)
  ) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (label_we),
    .waddr_i (ClAw'(req_i.cluster_index)),
    .wdata_i (req_i.label_value),
    .raddr_i (best_q),
    .rdata_o (label_rdata)
  );

  ncl1_ram #(
    .WIDTH (CoordW),
    .DEPTH (MAX_DIMS)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (point_we),
    .waddr_i (DimAw'(req_i.dim_index)),
    .wdata_i (req_i.coordinate),
    .raddr_i (dim_q),
    .rdata_o (point_rdata)
  );

  // clamp the configured counts into 1..max, kept as count minus one
  always_comb begin
    priority if (clusters_q == '0) begin
      ncl_m1_d = '0;
    end else if (int'(clusters_q) > MAX_CLUSTERS) begin
      ncl_m1_d = ClAw'(MAX_CLUSTERS - 1);
    end else begin
      ncl_m1_d = ClAw'(clusters_q - NclCfgW'(1));
    end
    priority if (dims_q == '0) begin
      ndim_m1_d = '0;
    end else if (int'(dims_q) > MAX_DIMS) begin
      ndim_m1_d = DimAw'(MAX_DIMS - 1);
    end else begin
      ndim_m1_d = DimAw'(dims_q - NdCfgW'(1));
    end
  end

  // absolute difference of point and centroid coordinate
  always_comb begin
    diff = {point_rdata[CoordW-1], point_rdata} - {cent_rdata[CoordW-1], cent_rdata};
    if (diff[CoordW]) begin
      absdiff_d = AbsW'(-diff);
    end else begin
      absdiff_d = AbsW'(diff);
    end
  end

  // running sum over the coordinates of one cluster
  always_comb begin
    if (s2_first_q) begin
      acc_d = DistW'(absdiff_q);
    end else begin
      acc_d = acc_q + DistW'(absdiff_q);
    end
  end

  // datapath registers, qualified by the valids below
  always_ff @(posedge clk_i) begin
    absdiff_q   <= absdiff_d;
    s2_first_q  <= s1_first_q;
    s2_last_q   <= s1_last_q;
    s2_lastcl_q <= s1_lastcl_q;
    if (s2_v_q) begin
      acc_q <= acc_d;
    end
    if (s2_v_q && s2_last_q) begin
      dist_q      <= acc_d;
      s3_lastcl_q <= s2_lastcl_q;
    end
  end

  // control, counters, search result and output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      clusters_q   <= NclCfgW'(256);
      dims_q       <= NdCfgW'(32);
      ncl_m1_q     <= '0;
      ndim_m1_q    <= '0;
      cl_q         <= '0;
      dim_q        <= '0;
      cent_addr_q  <= '0;
      base_q       <= '0;
      issue_done_q <= 1'b0;
      s1_v_q       <= 1'b0;
      s1_first_q   <= 1'b0;
      s1_last_q    <= 1'b0;
      s1_lastcl_q  <= 1'b0;
      s2_v_q       <= 1'b0;
      s3_v_q       <= 1'b0;
      fin_q        <= 1'b0;
      best_q       <= '0;
      best_dist_q  <= '0;
      cmp_idx_q    <= '0;
      done_q       <= 1'b0;
      res_q        <= '0;
    end else begin
      done_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CLUSTERS: clusters_q <= cfg_data_i;
          CFG_DIMS:     dims_q     <= NdCfgW'(cfg_data_i);
          default: ;
        endcase
      end

      // coordinate issue: one centroid coordinate per cycle
      s1_v_q <= 1'b0;
      if (state_q == S_RUN && !issue_done_q) begin
        s1_v_q      <= 1'b1;
        s1_first_q  <= (dim_q == '0);
        s1_last_q   <= (dim_q == ndim_m1_q);
        s1_lastcl_q <= (cl_q == ncl_m1_q);
        if (dim_q == ndim_m1_q) begin
          dim_q       <= '0;
          cl_q        <= cl_q + ClAw'(1);
          base_q      <= base_q + CentAw'(MAX_DIMS);
          cent_addr_q <= base_q + CentAw'(MAX_DIMS);
          if (cl_q == ncl_m1_q) begin
            issue_done_q <= 1'b1;
          end
        end else begin
          dim_q       <= dim_q + DimAw'(1);
          cent_addr_q <= cent_addr_q + CentAw'(1);
        end
      end

      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q && s2_last_q;

      // compare stage, strict less keeps the lowest index on a tie
      if (s3_v_q) begin
        if (cmp_idx_q == '0 || dist_q < best_dist_q) begin
          best_q      <= cmp_idx_q;
          best_dist_q <= dist_q;
        end
        cmp_idx_q <= cmp_idx_q + ClAw'(1);
        if (s3_lastcl_q) begin
          fin_q <= 1'b1;
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept && req_i.command == CMD_POINT && req_i.point_end) begin
            state_q      <= S_RUN;
            ncl_m1_q     <= ncl_m1_d;
            ndim_m1_q    <= ndim_m1_d;
            cl_q         <= '0;
            dim_q        <= '0;
            cent_addr_q  <= '0;
            base_q       <= '0;
            issue_done_q <= 1'b0;
            cmp_idx_q    <= '0;
            fin_q        <= 1'b0;
          end
        end
        S_RUN: begin
          // best index is final, label ram reads it this cycle
          if (fin_q) begin
            fin_q   <= 1'b0;
            state_q <= S_LABEL;
          end
        end
        S_LABEL: begin
          res_q.assigned_label  <= label_rdata;
          res_q.nearest_cluster <= ClIdxW'(best_q);
          done_q                <= 1'b1;
          state_q               <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // the result strobe lasts one cycle
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  // a result only follows the label read
  a_done_after_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == S_LABEL) && !busy)
    else $error("result without label read");

  // the pipeline only carries work during a search
  a_pipe_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q || s2_v_q || s3_v_q) |-> (state_q == S_RUN))
    else $error("pipeline active outside a search");

  // the search cannot end before every coordinate was issued
  a_fin_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> issue_done_q && !s1_v_q && !s2_v_q)
    else $error("search finished with coordinates in flight");

endmodule

`default_nettype wire
